/* rtl/ptme_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptme_pkg
// Shared constants, entry format and memory request type for the page table
// map engine.
// ----------------------------------------------------------------------------
package ptme_pkg;

    localparam int POOL_TABLES = 64;

    localparam int ENTRY_W  = 52;
    localparam int IDX_W    = 9;
    localparam int TBL_W    = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int CNT_W    = $clog2(POOL_TABLES + 1);
    localparam int ADDR_W   = TBL_W + IDX_W;
    localparam int PFN_W    = 40;

    // entry flag bit positions
    localparam int B_PRESENT = 0;
    localparam int B_WRITE   = 1;
    localparam int B_WTHRU   = 3;
    localparam int B_NOCACHE = 4;
    localparam int B_HUGE    = 7;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_LAYOUT    = 2'd2;
    localparam logic [1:0] ST_CONFLICT  = 2'd3;

    // request codes
    localparam logic CMD_4K = 1'b0;
    localparam logic CMD_2M = 1'b1;

    // store port: one access per cycle, read data registered
    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    addr;
        logic [ENTRY_W-1:0]   wdata;
        logic                 wflag;   // entry written while its table was allocated
    } t_mem_req;

endpackage
`default_nettype wire

/* rtl/ptme_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptme_store
// Single-port table store, registered read. Each word holds the
// entry plus a flag telling whether its table was allocated at write time.
// ----------------------------------------------------------------------------
module ptme_store (
    input  wire logic                       i_clk,
    input  wire ptme_pkg::t_mem_req         i_req,
    output logic [ptme_pkg::ENTRY_W:0]      o_rdata
);

    localparam int DEPTH = ptme_pkg::POOL_TABLES * (2 ** ptme_pkg::IDX_W);

    logic [ptme_pkg::ENTRY_W:0] r_mem [DEPTH];
    logic [ptme_pkg::ENTRY_W:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= {i_req.wflag, i_req.wdata};
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/ptme_walk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptme_walk
// Sequencer for the table walk: clearing sweep after reset, then per request
// a read / check-and-write pair for each level, allocation and leaf update.
// ----------------------------------------------------------------------------
module ptme_walk (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ptme_pkg::ENTRY_W-1:0]  i_pool_base,
    input  wire logic                          i_start,
    input  wire logic                          i_cmd,
    input  wire logic [63:0]                   i_virt,
    input  wire logic [ptme_pkg::ENTRY_W-1:0]  i_phys,
    input  wire logic                          i_uncached,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [1:0]                         o_status,
    output logic [ptme_pkg::CNT_W-1:0]         o_count,
    output ptme_pkg::t_mem_req                 o_req,
    input  wire logic [ptme_pkg::ENTRY_W:0]    i_rdata
);

    localparam int TBL_W   = ptme_pkg::TBL_W;
    localparam int CNT_W   = ptme_pkg::CNT_W;
    localparam int ADDR_W  = ptme_pkg::ADDR_W;
    localparam int ENTRY_W = ptme_pkg::ENTRY_W;
    localparam int PFN_W   = ptme_pkg::PFN_W;
    localparam int IDX_W   = ptme_pkg::IDX_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TBL_W-1:0]    r_tbl, n_tbl;
    logic [1:0]          r_level, n_level;
    logic                r_large, n_large;
    logic [35:0]         r_vpn, n_vpn;      // virt[47:12]
    logic [ENTRY_W-1:0]  r_wanted, n_wanted;
    logic                r_done, n_done;
    logic [1:0]          r_status, n_status;

    logic [IDX_W-1:0]    idx;
    logic [ADDR_W-1:0]   pos;
    logic                misaligned;
    logic [ENTRY_W-1:0]  want_in;
    logic                tbl_alloc;
    logic [ENTRY_W-1:0]  ent;
    logic [PFN_W-1:0]    off;
    logic                in_pool;
    logic                at_leaf;
    logic                pool_full;
    logic                link_flag;
    logic [PFN_W-1:0]    link_pfn;

    always_comb begin
        case (r_level)
            2'd0:    idx = r_vpn[35:27];
            2'd1:    idx = r_vpn[26:18];
            2'd2:    idx = r_vpn[17:9];
            default: idx = r_vpn[8:0];
        endcase
    end

    assign pos = {r_tbl, idx};

    always_comb begin
        if (i_cmd == ptme_pkg::CMD_2M) begin
            misaligned = (i_virt[20:0] != '0) || (i_phys[20:0] != '0);
        end else begin
            misaligned = (i_virt[11:0] != '0) || (i_phys[11:0] != '0);
        end
        want_in = i_phys;
        want_in[ptme_pkg::B_PRESENT] = 1'b1;
        want_in[ptme_pkg::B_WRITE]   = 1'b1;
        if (i_cmd == ptme_pkg::CMD_2M) begin
            want_in[ptme_pkg::B_HUGE] = 1'b1;
        end else if (i_uncached) begin
            want_in[ptme_pkg::B_WTHRU]   = 1'b1;
            want_in[ptme_pkg::B_NOCACHE] = 1'b1;
        end
    end

    // An entry written before its table was allocated reads as zero once
    // the table has been taken from the pool (allocation clears the table).
    assign tbl_alloc = CNT_W'(r_tbl) < r_count;
    assign ent       = (i_rdata[ENTRY_W] || !tbl_alloc) ? i_rdata[ENTRY_W-1:0] : '0;
    assign off       = ent[ENTRY_W-1:12] - i_pool_base[ENTRY_W-1:12];
    assign in_pool   = off < PFN_W'(ptme_pkg::POOL_TABLES);
    assign at_leaf   = r_level == (r_large ? 2'd2 : 2'd3);
    assign pool_full = r_count >= CNT_W'(ptme_pkg::POOL_TABLES);
    assign link_pfn  = i_pool_base[ENTRY_W-1:12] + PFN_W'(r_count);
    assign link_flag = {1'b0, CNT_W'(r_tbl)} < ({1'b0, r_count} + (CNT_W+1)'(1));

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_count  = r_count;
        n_tbl    = r_tbl;
        n_level  = r_level;
        n_large  = r_large;
        n_vpn    = r_vpn;
        n_wanted = r_wanted;
        n_done   = 1'b0;
        n_status = r_status;

        o_req.we    = 1'b0;
        o_req.addr  = pos;
        o_req.wdata = '0;
        o_req.wflag = 1'b0;

        case (r_state)
            S_CLEAR: begin
                o_req.we   = 1'b1;
                o_req.addr = r_clr;
                n_clr      = r_clr + ADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_large  = i_cmd;
                    n_vpn    = i_virt[47:12];
                    n_wanted = want_in;
                    n_tbl    = '0;
                    n_level  = 2'd0;
                    if (misaligned) begin
                        n_done   = 1'b1;
                        n_status = ptme_pkg::ST_LAYOUT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (at_leaf) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (ent[ptme_pkg::B_PRESENT] && (ent != r_wanted)) begin
                        n_status = ptme_pkg::ST_CONFLICT;
                    end else begin
                        n_status    = ptme_pkg::ST_OK;
                        o_req.we    = 1'b1;
                        o_req.wdata = r_wanted;
                        o_req.wflag = tbl_alloc;
                    end
                end else if (ent[ptme_pkg::B_PRESENT]) begin
                    if (ent[ptme_pkg::B_HUGE]) begin
                        n_state  = S_IDLE;
                        n_done   = 1'b1;
                        n_status = ptme_pkg::ST_CONFLICT;
                    end else if (!in_pool) begin
                        n_state  = S_IDLE;
                        n_done   = 1'b1;
                        n_status = ptme_pkg::ST_LAYOUT;
                    end else begin
                        n_tbl   = off[TBL_W-1:0];
                        n_level = r_level + 2'd1;
                        n_state = S_READ;
                    end
                end else if (pool_full) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ptme_pkg::ST_EXHAUSTED;
                end else begin
                    // allocate table r_count and link it here
                    o_req.we    = 1'b1;
                    o_req.wdata = {link_pfn, 12'h003};
                    o_req.wflag = link_flag;
                    n_tbl       = r_count[TBL_W-1:0];
                    n_count     = r_count + CNT_W'(1);
                    n_level     = r_level + 2'd1;
                    n_state     = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= CNT_W'(1);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tbl    <= n_tbl;
        r_level  <= n_level;
        r_large  <= n_large;
        r_vpn    <= n_vpn;
        r_wanted <= n_wanted;
        r_status <= n_status;
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_count  = r_count;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(1)) && (r_count <= CNT_W'(ptme_pkg::POOL_TABLES)))
        else $error("table count out of range");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_READ) |-> !o_req.we)
        else $error("store written outside clear or check");

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> ($past(r_state) == S_IDLE || $past(r_state) == S_CHECK))
        else $error("result raised from wrong state");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CHECK) |=> $stable(r_count))
        else $error("table count moved outside check");
`endif

endmodule
`default_nettype wire

/* rtl/page_table_map_engine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_table_map_engine_unit
// Four-level page table insert engine with an internal table pool.
// ----------------------------------------------------------------------------
// Walk: each level walked takes a store read, then a check and write; a
//   2 MiB request walks three levels and a 4 KiB request four. A misaligned
//   request answers in the cycle after the transfer, without a walk.
// Throughput: one request at a time; the single-port store sets the pace.
// Reset: after i_rst_n every word of the store is swept to zero with busy
//   high; configuration writes are taken during the sweep.
// Results are strobed for one cycle; the receiver cannot stall.
module page_table_map_engine_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ptme_pkg::ENTRY_W-1:0]  i_cfg_wdata,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cmd,
    input  wire logic [63:0]                   i_virt,
    input  wire logic [ptme_pkg::ENTRY_W-1:0]  i_phys,
    input  wire logic                          i_uncached,
    output logic                               o_done,
    output logic [1:0]                         o_status,
    output logic [6:0]                         o_tables_in_use
);

    logic [ptme_pkg::ENTRY_W-1:0] r_pool_base;
    logic [ptme_pkg::CNT_W-1:0]   count;
    logic [ptme_pkg::CNT_W+6:0]   count_ext;
    ptme_pkg::t_mem_req           mem_req;
    logic [ptme_pkg::ENTRY_W:0]   mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
        end else if (i_cfg_we) begin
            r_pool_base <= i_cfg_wdata;
        end
    end

    ptme_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pool_base (r_pool_base),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .i_virt      (i_virt),
        .i_phys      (i_phys),
        .i_uncached  (i_uncached),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_count     (count),
        .o_req       (mem_req),
        .i_rdata     (mem_rdata)
    );

    ptme_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign count_ext       = {7'd0, count};
    assign o_tables_in_use = count_ext[6:0];

endmodule
`default_nettype wire
